// ===== rtl/core/psr_pkg.sv =====
// psr_pkg: shared widths, constants, data types and arithmetic helpers of the
// plane-sailing polar/rectangular converter. Used by every module under rtl/core.
package psr_pkg;

   localparam int PSR_CORDIC_STAGES = 16;
   localparam int FRAC_BITS = 16;
   localparam int ANG_FRAC  = 24;
   localparam int GUARD     = 8;
   localparam int ANG_SHIFT = ANG_FRAC - FRAC_BITS;

   localparam int COURSE_W = 25;
   localparam int DIST_W   = 31;
   localparam int COORD_W  = 32;
   localparam int DOUT_W   = 32;

   // datapath widths: x/y carry guard bits plus cordic growth, z is degrees with 24 fraction bits
   localparam int XY_W   = 43;
   localparam int Z_W    = 35;
   localparam int GAIN_W = 42;

   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   localparam logic [COURSE_W-1:0] COURSE_FULL = COURSE_W'(360 << FRAC_BITS);

   localparam logic signed [Z_W-1:0] Z_FULL    = Z_W'(64'sd360 <<< ANG_FRAC);
   localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(64'sd180 <<< ANG_FRAC);
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd90 <<< ANG_FRAC);

   localparam logic signed [XY_W-1:0] S32_MAX = XY_W'(64'sd2147483647);
   localparam logic signed [XY_W-1:0] S32_MIN = XY_W'(-64'sd2147483648);

   // atan(2^-i) in degrees, 24 fraction bits
   localparam logic [30:0] ATAN_DEG [32] = '{
      31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
      31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
      31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
      31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
      31'd115, 31'd57, 31'd29, 31'd14, 31'd7, 31'd4, 31'd2, 31'd1, 31'd0
   };

   typedef struct packed {
      logic                   act;
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } psr_vec_type;

   // v * 0.6072529 with round to nearest, split into high and low 32-bit halves
   function automatic logic [GAIN_W-1:0] gain_mul(input logic [GAIN_W-1:0] v);
      logic [63:0]     lo_p;
      logic [GAIN_W:0] hi_p;
      logic [GAIN_W:0] sum;
      lo_p = 64'(v[31:0]) * 64'(GAIN_Q32) + 64'h0000_0000_8000_0000;
      hi_p = (GAIN_W+1)'(v[GAIN_W-1:32]) * (GAIN_W+1)'(GAIN_Q32);
      sum  = hi_p + (GAIN_W+1)'(lo_p[63:32]);
      return sum[GAIN_W-1:0];
   endfunction

   // drop guard bits, round half away from zero
   function automatic logic signed [XY_W-1:0] round_guard(input logic signed [XY_W-1:0] v);
      logic [XY_W-1:0] mag;
      logic [XY_W-1:0] r;
      mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
      r   = (mag + XY_W'(1 << (GUARD-1))) >> GUARD;
      return v[XY_W-1] ? -signed'(r) : signed'(r);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [XY_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > S32_MAX) begin
         r = S32_MAX[COORD_W-1:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/psr_prep.sv =====
// psr_prep: two front stages: course reduction and gain multiply, then quadrant
// fold and start vector for the cordic row. Depends on psr_pkg.
module psr_prep
   import psr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      action,
   input  logic [COURSE_W-1:0]       course_in,
   input  logic [DIST_W-1:0]         distance_in,
   input  logic signed [COORD_W-1:0] north_in,
   input  logic signed [COORD_W-1:0] east_in,
   output logic                      out_valid,
   input  logic                      out_ready,
   output psr_vec_type               out_vec
);

   logic                      a_valid_ff;
   logic                      a_act_ff;
   logic                      a_zero_ff;
   logic [COURSE_W-1:0]       a_course_ff;
   logic [GAIN_W-1:0]         a_mag_ff;
   logic signed [COORD_W-1:0] a_north_ff;
   logic signed [COORD_W-1:0] a_east_ff;
   logic                      b_valid_ff;
   psr_vec_type               b_vec_ff;

   logic                      a_ready;
   logic                      b_ready;
   logic [COURSE_W-1:0]       course_in_mod;
   logic [GAIN_W-1:0]         mag_in;

   logic signed [Z_W-1:0]     z_raw;
   logic signed [Z_W-1:0]     z_fold;
   logic signed [XY_W-1:0]    m_s;
   psr_vec_type               b_vec_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign course_in_mod = (course_in >= COURSE_FULL) ? course_in - COURSE_FULL : course_in;
   assign mag_in = gain_mul(GAIN_W'({distance_in, {GUARD{1'b0}}}));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_act_ff    <= action;
         a_zero_ff   <= (north_in == '0) && (east_in == '0);
         a_course_ff <= course_in_mod;
         a_mag_ff    <= mag_in;
         a_north_ff  <= north_in;
         a_east_ff   <= east_in;
      end
   end

   always_comb begin
      z_raw  = Z_W'({a_course_ff, {ANG_SHIFT{1'b0}}});
      z_fold = (z_raw > Z_HALF) ? z_raw - Z_FULL : z_raw;
      m_s    = XY_W'(a_mag_ff);
      b_vec_in.act  = a_act_ff;
      b_vec_in.zero = a_zero_ff;
      if (!a_act_ff) begin
         // beyond a quarter turn the start vector is pre-rotated by 90 degrees
         priority if (z_fold > Z_QUARTER) begin
            b_vec_in.x = '0;
            b_vec_in.y = m_s;
            b_vec_in.z = z_fold - Z_QUARTER;
         end else if (z_fold < -Z_QUARTER) begin
            b_vec_in.x = '0;
            b_vec_in.y = -m_s;
            b_vec_in.z = z_fold + Z_QUARTER;
         end else begin
            b_vec_in.x = m_s;
            b_vec_in.y = '0;
            b_vec_in.z = z_fold;
         end
      end else begin
         // southern half plane is turned by 180 degrees first
         if (a_north_ff[COORD_W-1]) begin
            b_vec_in.x = -(XY_W'(a_north_ff) <<< GUARD);
            b_vec_in.y = -(XY_W'(a_east_ff) <<< GUARD);
            b_vec_in.z = Z_HALF;
         end else begin
            b_vec_in.x = XY_W'(a_north_ff) <<< GUARD;
            b_vec_in.y = XY_W'(a_east_ff) <<< GUARD;
            b_vec_in.z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_vec_ff <= b_vec_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_vec   = b_vec_ff;

endmodule

// ===== rtl/core/psr_cell.sv =====
// psr_cell: one cordic micro-rotation with its own pipeline register, rotation
// mode driven by the angle sign, vectoring mode by the east sign. Depends on psr_pkg.
module psr_cell
   import psr_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  psr_vec_type in_vec,
   output logic        out_valid,
   input  logic        out_ready,
   output psr_vec_type out_vec
);

   localparam logic [4:0] IDX = 5'(SHIFT);

   logic                   valid_ff;
   psr_vec_type            vec_ff;
   psr_vec_type            vec_in;
   logic                   ready;
   logic signed [XY_W-1:0] x_sh;
   logic signed [XY_W-1:0] y_sh;
   logic signed [Z_W-1:0]  atan_z;
   logic                   neg_rot;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   always_comb begin
      x_sh    = $signed(in_vec.x) >>> SHIFT;
      y_sh    = $signed(in_vec.y) >>> SHIFT;
      atan_z  = Z_W'(ATAN_DEG[IDX]);
      // both modes share one update, only the decision bit differs
      neg_rot = in_vec.act ? !in_vec.y[XY_W-1] : in_vec.z[Z_W-1];
      vec_in.act  = in_vec.act;
      vec_in.zero = in_vec.zero;
      if (neg_rot) begin
         vec_in.x = in_vec.x + y_sh;
         vec_in.y = in_vec.y - x_sh;
         vec_in.z = in_vec.z + atan_z;
      end else begin
         vec_in.x = in_vec.x - y_sh;
         vec_in.y = in_vec.y + x_sh;
         vec_in.z = in_vec.z - atan_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// ===== rtl/core/psr_post.sv =====
// psr_post: gain removal, guard rounding, saturation and course wrap, ending in
// the result register. Depends on psr_pkg.
module psr_post
   import psr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  psr_vec_type                in_vec,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [COORD_W-1:0]  north_out,
   output logic signed [COORD_W-1:0]  east_out,
   output logic [COURSE_W-1:0]        course_out,
   output logic [DOUT_W-1:0]          distance_out
);

   logic                      p1_valid_ff;
   logic                      p1_act_ff;
   logic                      p1_zero_ff;
   logic signed [XY_W-1:0]    p1_north_ff;
   logic signed [XY_W-1:0]    p1_east_ff;
   logic [GAIN_W-1:0]         p1_mag_ff;
   logic [Z_W-1:0]            p1_z_ff;

   logic                      p2_valid_ff;
   logic                      p2_act_ff;
   logic signed [COORD_W-1:0] p2_north_ff;
   logic signed [COORD_W-1:0] p2_east_ff;
   logic [COURSE_W-1:0]       p2_course_ff;
   logic [DOUT_W-1:0]         p2_dist_ff;

   logic                      p1_ready;
   logic                      p2_ready;
   logic [XY_W-1:0]           x_clamp;
   logic signed [Z_W-1:0]     z_wrap;

   logic [GAIN_W:0]           dist_sum;
   logic [GAIN_W:0]           dist_sh;
   logic [DOUT_W-1:0]         dist_in;
   logic [Z_W-1:0]            crs_sum;
   logic [Z_W-1:0]            crs_sh;
   logic [COURSE_W-1:0]       crs_in;
   logic signed [COORD_W-1:0] north_in;
   logic signed [COORD_W-1:0] east_in;

   assign p2_ready = !p2_valid_ff || out_ready;
   assign p1_ready = !p1_valid_ff || p2_ready;
   assign in_ready = p1_ready;

   assign x_clamp = in_vec.x[XY_W-1] ? '0 : XY_W'(in_vec.x);
   assign z_wrap  = in_vec.z[Z_W-1] ? in_vec.z + Z_FULL : in_vec.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (p1_ready) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_ready && in_valid) begin
         p1_act_ff   <= in_vec.act;
         p1_zero_ff  <= in_vec.zero;
         p1_north_ff <= round_guard(in_vec.x);
         p1_east_ff  <= round_guard(in_vec.y);
         p1_mag_ff   <= gain_mul(x_clamp[GAIN_W-1:0]);
         p1_z_ff     <= Z_W'(z_wrap);
      end
   end

   always_comb begin
      dist_sum = (GAIN_W+1)'(p1_mag_ff) + (GAIN_W+1)'(1 << (GUARD-1));
      dist_sh  = dist_sum >> GUARD;
      dist_in  = (|dist_sh[GAIN_W:DOUT_W]) ? '1 : dist_sh[DOUT_W-1:0];
      crs_sum  = p1_z_ff + Z_W'(1 << (ANG_SHIFT-1));
      crs_sh   = crs_sum >> ANG_SHIFT;
      // a course that rounds up to a full turn reads as north
      crs_in   = (crs_sh >= Z_W'(COURSE_FULL)) ? '0 : crs_sh[COURSE_W-1:0];
      north_in = sat32(p1_north_ff);
      east_in  = sat32(p1_east_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (p2_ready) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_ready && p1_valid_ff) begin
         p2_act_ff <= p1_act_ff;
         if (!p1_act_ff) begin
            p2_north_ff  <= north_in;
            p2_east_ff   <= east_in;
            p2_course_ff <= '0;
            p2_dist_ff   <= '0;
         end else begin
            p2_north_ff  <= '0;
            p2_east_ff   <= '0;
            p2_course_ff <= p1_zero_ff ? '0 : crs_in;
            p2_dist_ff   <= p1_zero_ff ? '0 : dist_in;
         end
      end
   end

   assign out_valid    = p2_valid_ff;
   assign north_out    = p2_north_ff;
   assign east_out     = p2_east_ff;
   assign course_out   = p2_course_ff;
   assign distance_out = p2_dist_ff;

   // vectoring never drives x negative
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_vec.act |-> !in_vec.x[XY_W-1])
      else $error("psr_post: vectoring x went negative");

   assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> p2_course_ff < COURSE_FULL)
      else $error("psr_post: course beyond full turn");

   assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && !p2_act_ff |-> p2_course_ff == '0 && p2_dist_ff == '0)
      else $error("psr_post: polar fields set on rectangular result");

   assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && p2_act_ff |-> p2_north_ff == '0 && p2_east_ff == '0)
      else $error("psr_post: rectangular fields set on polar result");

endmodule

// ===== rtl/core/plane_sailing_polar_rect.sv =====
// plane_sailing_polar_rect: pipelined cordic converter between course/distance
// and northing/easting. Depends on psr_pkg, psr_prep, psr_cell, psr_post.
// Pipeline: two front stages, one cell per micro-rotation, two back stages
// ending in the result register. Throughput: one item per cycle while rsp_ready
// is high; every stage moves into an empty or draining one.
// Reset clears the stage valid flags only; no item is held across reset.
module plane_sailing_polar_rect
   import psr_pkg::*;
#(
   parameter int CORDIC_STAGES = PSR_CORDIC_STAGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic [COURSE_W-1:0]       req_course_in,
   input  logic [DIST_W-1:0]         req_distance_in,
   input  logic signed [COORD_W-1:0] req_north_in,
   input  logic signed [COORD_W-1:0] req_east_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_north_out,
   output logic signed [COORD_W-1:0] rsp_east_out,
   output logic [COURSE_W-1:0]       rsp_course_out,
   output logic [DOUT_W-1:0]         rsp_distance_out
);

   logic        link_valid [CORDIC_STAGES+1];
   logic        link_ready [CORDIC_STAGES+1];
   psr_vec_type link_vec   [CORDIC_STAGES+1];

   psr_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .action      (req_action),
      .course_in   (req_course_in),
      .distance_in (req_distance_in),
      .north_in    (req_north_in),
      .east_in     (req_east_in),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_vec     (link_vec[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      psr_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_vec    (link_vec[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_vec   (link_vec[g+1])
      );
   end

   psr_post u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (link_valid[CORDIC_STAGES]),
      .in_ready     (link_ready[CORDIC_STAGES]),
      .in_vec       (link_vec[CORDIC_STAGES]),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .north_out    (rsp_north_out),
      .east_out     (rsp_east_out),
      .course_out   (rsp_course_out),
      .distance_out (rsp_distance_out)
   );

endmodule

// ===== test/psr_fix_pkg.sv =====
// psr_fix_pkg: fix ledger for the plane-sailing converter bench, with its own
// cordic predictor of northing/easting and course/distance. Depends on psr_pkg widths.
`timescale 1ns / 1ps
package psr_fix_pkg;
   import psr_pkg::*;

   localparam int FIX_ROTATIONS = 16;
   localparam int SHOW_LIMIT = 50;

   // degrees with 24 fraction bits
   localparam longint Z_FULL = 64'sd6039797760;
   localparam longint Z_HALF = 64'sd3019898880;
   localparam longint Z_QTR  = 64'sd1509949440;
   localparam longint unsigned COURSE_SPAN = 64'd23592960;
   localparam longint unsigned GAIN_K = 64'd2608131496;

   localparam longint ARC [16] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] north;
      logic signed [COORD_W-1:0] east;
      logic [COURSE_W-1:0]       course;
      logic [DOUT_W-1:0]         distance;
   } sail_fix_type;

   class fix_ledger;
      sail_fix_type pending[$];
      int errors;
      int fixes_seen;
      int polar_items;
      int rect_items;
      int zero_vectors;

      function new();
         errors = 0;
         fixes_seen = 0;
         polar_items = 0;
         rect_items = 0;
         zero_vectors = 0;
      endfunction

      static function longint unsigned gain_scale(longint unsigned v);
         longint unsigned hi;
         longint unsigned lo;
         hi = v >> 32;
         lo = v & 64'hFFFF_FFFF;
         return hi * GAIN_K + ((lo * GAIN_K + 64'h8000_0000) >> 32);
      endfunction

      // both guard removal and degree narrowing drop 8 bits
      static function longint half_away(longint v);
         if (v >= 0) begin
            return (v + 128) >>> 8;
         end
         return -((-v + 128) >>> 8);
      endfunction

      static function logic signed [COORD_W-1:0] clamp32(longint v);
         if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
         end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
         end
         return v[31:0];
      endfunction

      static function sail_fix_type plot_fix(logic act, logic [COURSE_W-1:0] crs,
                                             logic [DIST_W-1:0] dst,
                                             logic signed [COORD_W-1:0] n,
                                             logic signed [COORD_W-1:0] e);
         longint x, y, z, nx, ny, m;
         longint unsigned c, mag, dist_rnd;
         int i;
         sail_fix_type f;
         f = '0;
         if (!act) begin
            c = longint'(crs);
            if (c >= COURSE_SPAN) begin
               c -= COURSE_SPAN;
            end
            m = longint'(gain_scale(longint'(dst) << 8));
            z = longint'(c << 8);
            if (z > Z_HALF) begin
               z -= Z_FULL;
            end
            x = m;
            y = 0;
            // fold the back half of the circle onto the cordic range
            if (z > Z_QTR) begin
               x = 0;
               y = m;
               z -= Z_QTR;
            end else if (z < -Z_QTR) begin
               x = 0;
               y = -m;
               z += Z_QTR;
            end
            for (i = 0; i < FIX_ROTATIONS; i++) begin
               if (z >= 0) begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z -= ARC[i];
               end else begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z += ARC[i];
               end
               x = nx;
               y = ny;
            end
            f.north = clamp32(half_away(x));
            f.east = clamp32(half_away(y));
         end else if (n != 0 || e != 0) begin
            x = longint'(n) * 256;
            y = longint'(e) * 256;
            z = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               z = Z_HALF;
            end
            for (i = 0; i < FIX_ROTATIONS; i++) begin
               if (y >= 0) begin
                  nx = x + (y >>> i);
                  ny = y - (x >>> i);
                  z += ARC[i];
               end else begin
                  nx = x - (y >>> i);
                  ny = y + (x >>> i);
                  z -= ARC[i];
               end
               x = nx;
               y = ny;
            end
            if (x < 0) begin
               x = 0;
            end
            mag = gain_scale(longint'(x));
            dist_rnd = (mag + 128) >> 8;
            if (dist_rnd > 64'hFFFF_FFFF) begin
               dist_rnd = 64'hFFFF_FFFF;
            end
            while (z < 0) begin
               z += Z_FULL;
            end
            while (z >= Z_FULL) begin
               z -= Z_FULL;
            end
            c = longint'(half_away(z));
            // a course rounding up to a full turn reads as north
            if (c >= COURSE_SPAN) begin
               c = 0;
            end
            f.course = c[COURSE_W-1:0];
            f.distance = dist_rnd[DOUT_W-1:0];
         end
         return f;
      endfunction

      function void note_input(logic act, logic [COURSE_W-1:0] crs,
                               logic [DIST_W-1:0] dst,
                               logic signed [COORD_W-1:0] n,
                               logic signed [COORD_W-1:0] e);
         if (act) begin
            rect_items++;
            if (n == 0 && e == 0) begin
               zero_vectors++;
            end
         end else begin
            polar_items++;
         end
         pending.push_back(plot_fix(act, crs, dst, n, e));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= SHOW_LIMIT) begin
            $display("mismatch on fix %0d: %s", fixes_seen, msg);
         end
      endtask

      task check_result(logic signed [COORD_W-1:0] n, logic signed [COORD_W-1:0] e,
                        logic [COURSE_W-1:0] crs, logic [DOUT_W-1:0] dst);
         sail_fix_type want;
         fixes_seen++;
         if (pending.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = pending.pop_front();
         if (n !== want.north) begin
            report($sformatf("north_out %0d, want %0d", n, want.north));
         end
         if (e !== want.east) begin
            report($sformatf("east_out %0d, want %0d", e, want.east));
         end
         if (crs !== want.course) begin
            report($sformatf("course_out %0d, want %0d", crs, want.course));
         end
         if (dst !== want.distance) begin
            report($sformatf("distance_out %0d, want %0d", dst, want.distance));
         end
      endtask
   endclass

endpackage

// ===== test/plane_sailing_polar_rect_tb.sv =====
// plane_sailing_polar_rect_tb: drives directed and random conversions through the
// converter with random idling on both channels. Depends on psr_pkg and psr_fix_pkg.
`timescale 1ns / 1ps
module plane_sailing_polar_rect_tb;
   import psr_pkg::*;
   import psr_fix_pkg::*;

   localparam int IDLE_PCT = 22;
   localparam int RANDOM_ITEMS = 1577;
   localparam int STALL_LIMIT = 2000;
   localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [COURSE_W-1:0] req_course_in = '0;
   logic [DIST_W-1:0] req_distance_in = '0;
   logic signed [COORD_W-1:0] req_north_in = '0;
   logic signed [COORD_W-1:0] req_east_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_north_out;
   logic signed [COORD_W-1:0] rsp_east_out;
   logic [COURSE_W-1:0] rsp_course_out;
   logic [DOUT_W-1:0] rsp_distance_out;

   bit calm = 1'b0;
   int quiet = 0;
   fix_ledger ledger = new();

   always #1 clock = ~clock;

   plane_sailing_polar_rect #(.CORDIC_STAGES(FIX_ROTATIONS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_course_in(req_course_in),
      .req_distance_in(req_distance_in),
      .req_north_in(req_north_in),
      .req_east_in(req_east_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_north_out(rsp_north_out),
      .rsp_east_out(rsp_east_out),
      .rsp_course_out(rsp_course_out),
      .rsp_distance_out(rsp_distance_out)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_result(rsp_north_out, rsp_east_out, rsp_course_out, rsp_distance_out);
      end
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_item(input logic act, input logic [COURSE_W-1:0] crs,
                            input logic [DIST_W-1:0] dst,
                            input logic signed [COORD_W-1:0] n,
                            input logic signed [COORD_W-1:0] e);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_course_in <= crs;
      req_distance_in <= dst;
      req_north_in <= n;
      req_east_in <= e;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      ledger.note_input(act, crs, dst, n, e);
   endtask

   // mostly full-range, with small values, zero axes and extremes mixed in
   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COORD_W'($urandom_range(0, 4000)) - 32'sd2000;
         2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
         3: return COORD_W'($urandom_range(0, 1 << 24)) - 32'sd8388608;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic act;
      logic [COURSE_W-1:0] crs;
      logic [DIST_W-1:0] dst;
      logic signed [COORD_W-1:0] n, e;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // quadrant boundaries, out-of-range courses and extreme distances
      send_item(1'b0, '0, DIST_MAX, '0, '0);
      send_item(1'b0, 25'(90 << 16), 31'(1 << 16), '0, '0);
      send_item(1'b0, 25'(180 << 16), 31'(1 << 16), '0, '0);
      send_item(1'b0, 25'(270 << 16), 31'(1 << 16), '0, '0);
      send_item(1'b0, 25'(135 << 16), 31'(5 << 16), '0, '0);
      send_item(1'b0, 25'(225 << 16), 31'(5 << 16), '0, '0);
      send_item(1'b0, 25'd23592959, 31'd123456789, '0, '0);
      send_item(1'b0, 25'd23592960, 31'd1000, '0, '0);
      send_item(1'b0, 25'h1FF_FFFF, DIST_MAX, '0, '0);
      send_item(1'b0, 25'(45 << 16), DIST_MAX, '0, '0);
      send_item(1'b0, 25'(30 << 16), '0, '0, '0);
      // zero vector, axes, far corners and a course just short of north
      send_item(1'b1, '0, '0, '0, '0);
      send_item(1'b1, '0, '0, C_MAX, '0);
      send_item(1'b1, '0, '0, C_MIN, '0);
      send_item(1'b1, '0, '0, '0, C_MAX);
      send_item(1'b1, '0, '0, '0, C_MIN);
      send_item(1'b1, '0, '0, C_MIN, C_MIN);
      send_item(1'b1, '0, '0, C_MAX, C_MAX);
      send_item(1'b1, '0, '0, C_MAX, -32'sd1);
      send_item(1'b1, '0, '0, -32'sd1, '0);
      send_item(1'b1, '0, '0, 32'sd1, 32'sd1);
      send_item(1'b1, '0, '0, -32'sd5, -32'sd7);
      send_item(1'b1, '0, '0, '0, 32'sd1);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         calm <= (k >= 500 && k < 900);
         act = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: crs = COURSE_W'($urandom);
            1: crs = COURSE_W'($urandom_range(0, 3) * (90 << 16) + $urandom_range(0, 8))
                     - 25'd4;
            default: crs = COURSE_W'($urandom_range(0, 23592959));
         endcase
         case ($urandom_range(0, 7))
            0: dst = DIST_W'($urandom_range(0, 1 << 20));
            1: dst = DIST_MAX - DIST_W'($urandom_range(0, 255));
            default: dst = DIST_W'($urandom);
         endcase
         n = pick_coord();
         e = pick_coord();
         send_item(act, crs, dst, n, e);
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      while (ledger.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (FIX_ROTATIONS + 8) @(posedge clock);

      $display("checked %0d fixes: %0d course/distance to north/east, %0d north/east back",
               ledger.fixes_seen, ledger.polar_items, ledger.rect_items);
      $display("%0d zero vectors among them, %0d mismatches", ledger.zero_vectors,
               ledger.errors);
      if (ledger.errors == 0 && ledger.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
